// ===== rtl/zpfc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zpfc_pkg
// Shared widths, register reset values and the item type passed from the
// sample sequencer to the tap cells of the zero-padded FIR correlator.
// ----------------------------------------------------------------------------
package zpfc_pkg;

  // Sample, coefficient and product widths.
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned COEFF_W  = 16;
  localparam int unsigned PROD_W   = SAMPLE_W + COEFF_W;
  localparam int unsigned FRAC_W   = 15;

  // Configuration register file.
  localparam int unsigned NREGS     = 7;
  localparam int unsigned CFG_IDX_W = 3;

  typedef logic signed [COEFF_W-1:0] coeff_t;

  // Reset values: a unit impulse on the centre tap.
  localparam coeff_t COEFF_RESET [NREGS] = '{
    16'sd0, 16'sd0, 16'sd0, 16'sd32767, 16'sd0, 16'sd0, 16'sd0
  };

  // One step of the filter: a real or zero-padding sample with its tags.
  typedef struct packed {
    logic                       valid;
    logic signed [SAMPLE_W-1:0] value;
    logic                       emit;   // this step completes an output point
    logic                       last;   // final step of the signal
  } feed_t;

endpackage

// ===== rtl/zpfc_feed.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zpfc_feed
// Turns accepted samples into filter steps. It counts samples up to HALF to
// know when an output point is complete, and after the final sample it
// inserts HALF zero samples while holding off the input channel.
// ----------------------------------------------------------------------------
module zpfc_feed import zpfc_pkg::*; #(
  parameter int unsigned HALF = 3
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  input  logic                       final_sample_i,
  input  logic                       ready_i,
  output feed_t                      feed_o,
  output logic                       take_o
);

  localparam int unsigned CNT_W = (HALF > 0) ? $clog2(HALF + 1) : 1;
  localparam logic [CNT_W-1:0] HALF_C = CNT_W'(HALF);
  localparam logic [CNT_W-1:0] ONE_C  = CNT_W'(1);

  logic [CNT_W-1:0] fill_q, fill_d;
  logic [CNT_W-1:0] flush_q, flush_d;
  logic             flushing;
  logic [CNT_W-1:0] fill_inc;

  assign flushing = (flush_q != '0);

  // Build the current step from the input or from the flush counter.
  always_comb begin
    feed_o.valid = flushing || in_valid_i;
    feed_o.value = flushing ? '0 : sample_i;
    feed_o.emit  = (fill_q >= HALF_C);
    if (flushing) begin
      feed_o.last = (flush_q == ONE_C);
    end else begin
      feed_o.last = final_sample_i && (HALF == 0);
    end
  end

  assign in_stall_o = flushing || !ready_i;
  assign take_o     = feed_o.valid && ready_i;
  assign fill_inc   = (fill_q < HALF_C) ? fill_q + ONE_C : fill_q;

  // Sample count and flush counter.
  always_comb begin
    fill_d  = fill_q;
    flush_d = flush_q;
    if (take_o) begin
      if (feed_o.last) begin
        fill_d  = '0;
        flush_d = '0;
      end else if (flushing) begin
        fill_d  = fill_inc;
        flush_d = flush_q - ONE_C;
      end else begin
        fill_d = fill_inc;
        if (final_sample_i) begin
          flush_d = HALF_C;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      flush_q <= '0;
    end else begin
      fill_q  <= fill_d;
      flush_q <= flush_d;
    end
  end

endmodule

// ===== rtl/zpfc_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zpfc_cell
// One tap of the transposed FIR chain. It registers the product of its
// coefficient with the broadcast sample, then adds it to the partial sum
// handed over by its neighbour and keeps the result for the next cell.
// ----------------------------------------------------------------------------
module zpfc_cell import zpfc_pkg::*; #(
  parameter int unsigned ACC_W = 35
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       load_i,
  input  logic signed [SAMPLE_W-1:0] x_i,
  input  coeff_t                     coeff_i,
  input  logic                       shift_i,
  input  logic                       clear_i,
  input  logic signed [ACC_W-1:0]    sum_i,
  output logic signed [ACC_W-1:0]    sum_o
);

  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  sum_q, sum_d;

  // Product stage.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      prod_q <= x_i * coeff_i;
    end
  end

  // Partial sum stage; cleared at the end of a signal.
  assign sum_d = clear_i ? '0 : (ACC_W'(prod_q) + sum_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else if (shift_i) begin
      sum_q <= sum_d;
    end
  end

  assign sum_o = sum_q;

endmodule

// ===== rtl/zero_padded_fir_correlator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zero_padded_fir_correlator
// Centred, zero-padded FIR correlation of a 16-bit sample stream with TAPS
// programmable Q1.15 coefficients, rounded and saturated to 16 bits.
// ----------------------------------------------------------------------------
// Usage:
// Samples enter on in_valid_i / in_stall_o with final_sample_i marking the
// last sample of a signal. Results leave on out_valid_o / out_stall_i, and
// final_result_o marks the last result of a signal. Coefficients are written
// through cfg_valid_i / cfg_ready_o with cfg_index_i selecting coeff_0 to
// coeff_6; write them only while the block is idle.
// Each output point i appears once sample i + TAPS/2 has been accepted and
// that item has passed the product stage, the chain stage and the output
// register. One sample is taken per cycle while the pipeline is not stalled.
// After a final sample the block inserts TAPS/2 zero samples, one per cycle
// unless stalled, and holds in_stall_o high while inserting them.
// Reset clears the tap chain and sample count and loads the coefficients
// with an impulse on coeff_3. When out_stall_i is held, the output register
// keeps its item and the pipeline stages behind it fill and then stall the
// input.
// ----------------------------------------------------------------------------
module zero_padded_fir_correlator import zpfc_pkg::*; #(
  parameter int unsigned TAPS = 7
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Configuration write channel.
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [COEFF_W-1:0]          cfg_data_i,
  // Sample channel.
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic signed [SAMPLE_W-1:0]  sample_i,
  input  logic                        final_sample_i,
  // Result channel.
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic signed [SAMPLE_W-1:0]  filtered_o,
  output logic                        final_result_o
);

  localparam int unsigned HALF  = TAPS / 2;
  localparam int unsigned NCELL = 2 * HALF + 1;
  localparam int unsigned ACC_W = PROD_W + ((NCELL > 1) ? $clog2(NCELL) : 1);
  localparam int unsigned RND_W = ACC_W + 1;
  localparam int unsigned Q_W   = RND_W - FRAC_W;

  localparam logic signed [RND_W-1:0] RND_HALF = RND_W'(1) <<< (FRAC_W - 1);
  localparam logic signed [Q_W-1:0]   SAT_MAX  = Q_W'(32767);
  localparam logic signed [Q_W-1:0]   SAT_MIN  = -Q_W'(32768);

  // Coefficient registers.
  coeff_t coeff_q [NREGS];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NREGS; i++) begin
        coeff_q[i] <= COEFF_RESET[i];
      end
    end else if (cfg_valid_i && (32'(cfg_index_i) < NREGS)) begin
      coeff_q[cfg_index_i] <= cfg_data_i;
    end
  end

  // Pipeline handshake: product stage, chain stage, output register.
  feed_t feed;
  logic  take;
  logic  p_valid_q, p_emit_q, p_last_q;
  logic  c_valid_q, c_last_q;
  logic  out_valid_q, final_q;
  logic signed [SAMPLE_W-1:0] filtered_q;
  logic  o_free, c_move, c_adv, p_free;

  assign o_free = !out_valid_q || !out_stall_i;
  assign c_move = c_valid_q && o_free;
  assign c_adv  = p_valid_q && (!c_valid_q || o_free);
  assign p_free = !p_valid_q || c_adv;

  zpfc_feed #(
    .HALF (HALF)
  ) u_feed (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .sample_i       (sample_i),
    .final_sample_i (final_sample_i),
    .ready_i        (p_free),
    .feed_o         (feed),
    .take_o         (take)
  );

  // Tags of the item in the product stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
      p_emit_q  <= 1'b0;
      p_last_q  <= 1'b0;
    end else if (take) begin
      p_valid_q <= 1'b1;
      p_emit_q  <= feed.emit;
      p_last_q  <= feed.last;
    end else if (c_adv) begin
      p_valid_q <= 1'b0;
    end
  end

  // Tap chain: cell j weights the sample that is j steps old.
  logic signed [ACC_W-1:0] chain [NCELL+1];

  assign chain[NCELL] = '0;

  for (genvar j = 0; j < NCELL; j++) begin : g_cell
    localparam int unsigned K = 2 * HALF - j;
    coeff_t cell_coeff;

    if (K < TAPS) begin : g_tap
      assign cell_coeff = coeff_q[K];
    end else begin : g_pad
      assign cell_coeff = '0;
    end

    zpfc_cell #(
      .ACC_W (ACC_W)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .load_i  (take),
      .x_i     (feed.value),
      .coeff_i (cell_coeff),
      .shift_i (c_adv),
      .clear_i (p_last_q && (j != 0)),
      .sum_i   (chain[j+1]),
      .sum_o   (chain[j])
    );
  end

  // A completed point waits in the head cell until the output takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
      c_last_q  <= 1'b0;
    end else if (c_adv) begin
      c_valid_q <= p_emit_q;
      c_last_q  <= p_last_q;
    end else if (c_move) begin
      c_valid_q <= 1'b0;
    end
  end

  // Round half up at bit 15, then saturate to 16 bits.
  logic signed [RND_W-1:0]    rnd;
  logic signed [Q_W-1:0]      quo;
  logic signed [SAMPLE_W-1:0] sat;

  always_comb begin
    rnd = RND_W'(chain[0]) + RND_HALF;
    quo = Q_W'(rnd >>> FRAC_W);
    if (quo > SAT_MAX) begin
      sat = SAMPLE_W'(SAT_MAX);
    end else if (quo < SAT_MIN) begin
      sat = SAMPLE_W'(SAT_MIN);
    end else begin
      sat = SAMPLE_W'(quo);
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (c_move) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (c_move) begin
      filtered_q <= sat;
      final_q    <= c_last_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign filtered_o     = filtered_q;
  assign final_result_o = final_q;

endmodule
